/* rtl/core/gnd_pkg.sv */
// ----------------------------------------------------------------------------
// gnd_pkg
// Types, constants and note tables shared by the note dispenser modules.
// ----------------------------------------------------------------------------
package gnd_pkg;

  // Number of note denominations and the width of an index over them.
  localparam int NUM_DENOMS = 5;
  localparam int IDX_W      = 3;

  // Field widths of the request and result words.
  localparam int AMT_W      = 32;
  localparam int DEP_W      = 16;
  localparam int TAKE_W     = 28;
  localparam int DENOM_W    = 9;
  localparam int RECIP_W    = 28;

  localparam int OUT20_W    = 28;
  localparam int OUT50_W    = 27;
  localparam int OUT100_W   = 26;
  localparam int OUT200_W   = 25;
  localparam int OUT500_W   = 24;

  // Denomination indexes, smallest note first.
  localparam logic [IDX_W-1:0] IDX_20  = 3'd0;
  localparam logic [IDX_W-1:0] IDX_50  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_100 = 3'd2;
  localparam logic [IDX_W-1:0] IDX_200 = 3'd3;
  localparam logic [IDX_W-1:0] IDX_500 = 3'd4;

  // Request type codes.
  localparam logic REQ_DEPOSIT  = 1'b0;
  localparam logic REQ_WITHDRAW = 1'b1;

  // Input word.
  typedef struct packed {
    logic               req_type;
    logic [AMT_W-1:0]   amount;
    logic [DEP_W-1:0]   deposit_twenty;
    logic [DEP_W-1:0]   deposit_fifty;
    logic [DEP_W-1:0]   deposit_hundred;
    logic [DEP_W-1:0]   deposit_two_hundred;
    logic [DEP_W-1:0]   deposit_five_hundred;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic                ok;
    logic [OUT20_W-1:0]  out_twenty;
    logic [OUT50_W-1:0]  out_fifty;
    logic [OUT100_W-1:0] out_hundred;
    logic [OUT200_W-1:0] out_two_hundred;
    logic [OUT500_W-1:0] out_five_hundred;
  } out_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_SEL,
    ST_SUB,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             mul;
    logic             rem;
    logic             sel;
    logic             sub;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_withdraw;
    logic out_free;
  } ctrl_sts_t;

  // Face value of a note.
  function automatic logic [DENOM_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
    logic [DENOM_W-1:0] val;
    unique case (idx)
      IDX_20:  val = 9'd20;
      IDX_50:  val = 9'd50;
      IDX_100: val = 9'd100;
      IDX_200: val = 9'd200;
      IDX_500: val = 9'd500;
      default: val = 9'd500;
    endcase
    return val;
  endfunction

  // Reciprocal floor(2^32 / value); the quotient estimate is low by at most one.
  function automatic logic [RECIP_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
    logic [RECIP_W-1:0] val;
    unique case (idx)
      IDX_20:  val = 28'd214748364;
      IDX_50:  val = 28'd85899345;
      IDX_100: val = 28'd42949672;
      IDX_200: val = 28'd21474836;
      IDX_500: val = 28'd8589934;
      default: val = 28'd8589934;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/gnd_ctrl.sv */
// ----------------------------------------------------------------------------
// gnd_ctrl
// Sequencer that steps the datapath through a deposit or a greedy withdrawal.
// ----------------------------------------------------------------------------
module gnd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gnd_pkg::ctrl_sts_t  sts,
  output gnd_pkg::ctrl_cmd_t  cmd
);

  gnd_pkg::state_t                state_r;
  gnd_pkg::state_t                state_nxt;
  logic [gnd_pkg::IDX_W-1:0]      idx_r;
  logic [gnd_pkg::IDX_W-1:0]      idx_nxt;

  // State and denomination index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnd_pkg::ST_IDLE;
      idx_r   <= gnd_pkg::IDX_500;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state: four steps per denomination, largest note first; a deposit goes straight to the finish state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      gnd_pkg::ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = gnd_pkg::IDX_500;
          if (sts.in_withdraw) begin
            state_nxt = gnd_pkg::ST_MUL;
          end else begin
            state_nxt = gnd_pkg::ST_FIN;
          end
        end
      end
      gnd_pkg::ST_MUL: state_nxt = gnd_pkg::ST_REM;
      gnd_pkg::ST_REM: state_nxt = gnd_pkg::ST_SEL;
      gnd_pkg::ST_SEL: state_nxt = gnd_pkg::ST_SUB;
      gnd_pkg::ST_SUB: begin
        if (idx_r == gnd_pkg::IDX_20) begin
          state_nxt = gnd_pkg::ST_FIN;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = gnd_pkg::ST_MUL;
        end
      end
      gnd_pkg::ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = gnd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gnd_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_stall = (state_r != gnd_pkg::ST_IDLE);
    cmd.load = (state_r == gnd_pkg::ST_IDLE) && in_valid;
    cmd.mul  = (state_r == gnd_pkg::ST_MUL);
    cmd.rem  = (state_r == gnd_pkg::ST_REM);
    cmd.sel  = (state_r == gnd_pkg::ST_SEL);
    cmd.sub  = (state_r == gnd_pkg::ST_SUB);
    cmd.fin  = (state_r == gnd_pkg::ST_FIN) && sts.out_free;
    cmd.idx  = idx_r;
  end

endmodule

/* rtl/core/gnd_datapath.sv */
// ----------------------------------------------------------------------------
// gnd_datapath
// Note stock, quotient unit and result register of the note dispenser.
// ----------------------------------------------------------------------------
module gnd_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gnd_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gnd_pkg::out_word_t  out_data,
  input  gnd_pkg::ctrl_cmd_t  cmd,
  output gnd_pkg::ctrl_sts_t  sts
);

  localparam int CMP_W = (COUNT_WIDTH > gnd_pkg::TAKE_W) ? COUNT_WIDTH : gnd_pkg::TAKE_W;
  localparam int SUM_W = ((COUNT_WIDTH > gnd_pkg::DEP_W) ? COUNT_WIDTH : gnd_pkg::DEP_W) + 1;
  localparam int PROD_W = gnd_pkg::AMT_W + gnd_pkg::RECIP_W;
  localparam int QD_W   = gnd_pkg::TAKE_W + gnd_pkg::DENOM_W;

  gnd_pkg::in_word_t              req_r;
  logic [gnd_pkg::AMT_W-1:0]      left_r;
  logic [gnd_pkg::TAKE_W-1:0]     qest_r;
  logic [gnd_pkg::AMT_W-1:0]      rem_r;
  logic [gnd_pkg::TAKE_W-1:0]     n_r;
  logic [gnd_pkg::TAKE_W-1:0]     take_r  [gnd_pkg::NUM_DENOMS];
  logic [COUNT_WIDTH-1:0]         stock_r [gnd_pkg::NUM_DENOMS];
  logic                           out_valid_r;
  gnd_pkg::out_word_t             out_word_r;

  logic [gnd_pkg::DENOM_W-1:0]    denom;
  logic [PROD_W-1:0]              prod;
  logic [QD_W-1:0]                qd;
  logic                           q_low;
  logic [gnd_pkg::TAKE_W-1:0]     q;
  logic [CMP_W-1:0]               q_ext;
  logic [CMP_W-1:0]               stock_ext;
  logic [gnd_pkg::TAKE_W-1:0]     n;
  logic [QD_W-1:0]                nd;
  logic [gnd_pkg::DEP_W-1:0]      dep     [gnd_pkg::NUM_DENOMS];
  logic [COUNT_WIDTH-1:0]         dep_sum [gnd_pkg::NUM_DENOMS];
  logic [COUNT_WIDTH-1:0]         wd_diff [gnd_pkg::NUM_DENOMS];
  logic                           ok;
  logic                           is_withdraw;

  assign sts.in_withdraw = (in_data.req_type == gnd_pkg::REQ_WITHDRAW);
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_word_r;

  // Quotient unit: reciprocal estimate, remainder, one-step correction.
  always_comb begin
    denom     = gnd_pkg::denom_value(cmd.idx);
    prod      = PROD_W'(left_r) * PROD_W'(gnd_pkg::denom_recip(cmd.idx));
    qd        = QD_W'(qest_r) * QD_W'(denom);
    q_low     = (rem_r >= gnd_pkg::AMT_W'(denom));
    q         = qest_r + gnd_pkg::TAKE_W'(q_low);
    q_ext     = CMP_W'(q);
    stock_ext = CMP_W'(stock_r[cmd.idx]);
    // Never more notes than the stock holds.
    if (q_ext <= stock_ext) begin
      n = q;
    end else begin
      n = stock_ext[gnd_pkg::TAKE_W-1:0];
    end
    nd = QD_W'(n_r) * QD_W'(denom);
  end

  // Stock updates for deposits (saturating) and accepted withdrawals.
  always_comb begin
    dep[0] = req_r.deposit_twenty;
    dep[1] = req_r.deposit_fifty;
    dep[2] = req_r.deposit_hundred;
    dep[3] = req_r.deposit_two_hundred;
    dep[4] = req_r.deposit_five_hundred;
    for (int i = 0; i < gnd_pkg::NUM_DENOMS; i++) begin
      logic [SUM_W-1:0] sum;
      logic [CMP_W-1:0] diff;
      sum  = SUM_W'(stock_r[i]) + SUM_W'(dep[i]);
      if (sum > SUM_W'({COUNT_WIDTH{1'b1}})) begin
        dep_sum[i] = {COUNT_WIDTH{1'b1}};
      end else begin
        dep_sum[i] = sum[COUNT_WIDTH-1:0];
      end
      diff       = CMP_W'(stock_r[i]) - CMP_W'(take_r[i]);
      wd_diff[i] = diff[COUNT_WIDTH-1:0];
    end
    is_withdraw = (req_r.req_type == gnd_pkg::REQ_WITHDRAW);
    ok          = !is_withdraw || (left_r == '0);
  end

  // Working registers of one request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_data;
      left_r <= in_data.amount;
    end
    if (cmd.mul) begin
      qest_r <= prod[gnd_pkg::AMT_W +: gnd_pkg::TAKE_W];
    end
    if (cmd.rem) begin
      rem_r <= left_r - qd[gnd_pkg::AMT_W-1:0];
    end
    if (cmd.sel) begin
      n_r              <= n;
      take_r[cmd.idx]  <= n;
    end
    if (cmd.sub) begin
      left_r <= left_r - nd[gnd_pkg::AMT_W-1:0];
    end
  end

  // Note stock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gnd_pkg::NUM_DENOMS; i++) begin
        stock_r[i] <= '0;
      end
    end else if (cmd.fin) begin
      for (int i = 0; i < gnd_pkg::NUM_DENOMS; i++) begin
        if (!is_withdraw) begin
          stock_r[i] <= dep_sum[i];
        end else if (ok) begin
          stock_r[i] <= wd_diff[i];
        end
      end
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: word. Counts are zero on deposits and refusals.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_word_r.ok <= ok;
      if (is_withdraw && ok) begin
        out_word_r.out_twenty       <= take_r[0][gnd_pkg::OUT20_W-1:0];
        out_word_r.out_fifty        <= take_r[1][gnd_pkg::OUT50_W-1:0];
        out_word_r.out_hundred      <= take_r[2][gnd_pkg::OUT100_W-1:0];
        out_word_r.out_two_hundred  <= take_r[3][gnd_pkg::OUT200_W-1:0];
        out_word_r.out_five_hundred <= take_r[4][gnd_pkg::OUT500_W-1:0];
      end else begin
        out_word_r.out_twenty       <= '0;
        out_word_r.out_fifty        <= '0;
        out_word_r.out_hundred      <= '0;
        out_word_r.out_two_hundred  <= '0;
        out_word_r.out_five_hundred <= '0;
      end
    end
  end

endmodule

/* rtl/core/greedy_note_dispenser.sv */
// ----------------------------------------------------------------------------
// greedy_note_dispenser
// Withdrawal: four steps per note (multiply, remainder, correct and clamp,
// subtract) for each of five notes, largest first, then a stock update.
// Deposit: skips the note steps and goes straight to the stock update.
// Next word accepted when idle again, later while a stalled result blocks.
// Reset clears all stock counts to zero and empties the output register.
// ----------------------------------------------------------------------------
module greedy_note_dispenser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gnd_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gnd_pkg::out_word_t  out_data
);

  gnd_pkg::ctrl_cmd_t cmd;
  gnd_pkg::ctrl_sts_t sts;

  // Sequencer.
  gnd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stock and arithmetic.
  gnd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* tb/sv/greedy_note_dispenser_test.sv */
// ----------------------------------------------------------------------------
// greedy_note_dispenser_test
// Self-checking testbench for the greedy note dispenser. A short table of
// directed requests covers the empty stock, zero and maximum amounts, greedy
// refusals and deposits of full counts. A long random run with bursty input
// and a patterned output stall follows; a deposit, a few large withdrawals
// and twelve more random words close the run. Every result word is checked
// against a local model of the note stock.
// ----------------------------------------------------------------------------
module greedy_note_dispenser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              COUNT_W      = 32;
  localparam longint unsigned COUNT_TOP    = (64'd1 << COUNT_W) - 1;
  localparam int              RANDOM_WORDS = 1950;
  localparam int              CYCLE_LIMIT  = 4_000_000;
  localparam int              SETTLE_CYCLES = 40;
  localparam int              REPORT_LIMIT = 10;

  // Output stall patterns.
  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  // One row of the directed table. A typed row carries its expected ok bit;
  // its dispensed counts are all zero.
  typedef struct {
    gnd_pkg::in_word_t word;
    bit                typed;
    logic              want_ok;
  } stim_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  gnd_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gnd_pkg::out_word_t out_data;

  // Model of the stock, indexed smallest note first.
  longint unsigned note_stock_model [gnd_pkg::NUM_DENOMS];
  longint unsigned note_value [gnd_pkg::NUM_DENOMS] = '{20, 50, 100, 200, 500};

  gnd_pkg::out_word_t pending_payouts [$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;
  bit        calm_mode   = 1'b0;
  rx_mode_t  rx_mode     = RX_OPEN;
  int        rx_left     = 0;
  int        rx_tick     = 0;

  greedy_note_dispenser #(
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the stock model and return the expected payout.
  function automatic gnd_pkg::out_word_t apply_request(input gnd_pkg::in_word_t w);
    longint unsigned    added [gnd_pkg::NUM_DENOMS];
    longint unsigned    take [gnd_pkg::NUM_DENOMS];
    longint unsigned    left;
    longint unsigned    n;
    gnd_pkg::out_word_t res;
    added = '{w.deposit_twenty, w.deposit_fifty, w.deposit_hundred,
              w.deposit_two_hundred, w.deposit_five_hundred};
    take  = '{default: 0};
    res   = '0;
    if (w.req_type == gnd_pkg::REQ_DEPOSIT) begin
      // Each count saturates at the top of the counter.
      for (int i = 0; i < gnd_pkg::NUM_DENOMS; i++) begin
        if (added[i] > COUNT_TOP - note_stock_model[i]) begin
          note_stock_model[i] = COUNT_TOP;
        end else begin
          note_stock_model[i] = note_stock_model[i] + added[i];
        end
      end
      res.ok = 1'b1;
    end else begin
      // Greedy pass from the largest note down.
      left = w.amount;
      for (int i = gnd_pkg::NUM_DENOMS - 1; i >= 0; i--) begin
        n = left / note_value[i];
        if (n > note_stock_model[i]) begin
          n = note_stock_model[i];
        end
        take[i] = n;
        left    = left - n * note_value[i];
      end
      if (left == 0) begin
        for (int i = 0; i < gnd_pkg::NUM_DENOMS; i++) begin
          note_stock_model[i] = note_stock_model[i] - take[i];
        end
        res.ok               = 1'b1;
        res.out_twenty       = gnd_pkg::OUT20_W'(take[gnd_pkg::IDX_20]);
        res.out_fifty        = gnd_pkg::OUT50_W'(take[gnd_pkg::IDX_50]);
        res.out_hundred      = gnd_pkg::OUT100_W'(take[gnd_pkg::IDX_100]);
        res.out_two_hundred  = gnd_pkg::OUT200_W'(take[gnd_pkg::IDX_200]);
        res.out_five_hundred = gnd_pkg::OUT500_W'(take[gnd_pkg::IDX_500]);
      end
    end
    return res;
  endfunction

  function automatic stim_row_t withdraw_row(input logic [gnd_pkg::AMT_W-1:0] amt,
                                             input bit typed = 1'b0,
                                             input logic want_ok = 1'b0);
    stim_row_t r;
    // Deposit fields carry noise that a withdrawal must ignore.
    r.word                      = '1;
    r.word.req_type             = gnd_pkg::REQ_WITHDRAW;
    r.word.amount               = amt;
    r.typed                     = typed;
    r.want_ok                   = want_ok;
    return r;
  endfunction

  function automatic stim_row_t deposit_row(input logic [gnd_pkg::DEP_W-1:0] c20,
                                            input logic [gnd_pkg::DEP_W-1:0] c50,
                                            input logic [gnd_pkg::DEP_W-1:0] c100,
                                            input logic [gnd_pkg::DEP_W-1:0] c200,
                                            input logic [gnd_pkg::DEP_W-1:0] c500,
                                            input bit typed = 1'b0);
    stim_row_t r;
    r.word.req_type             = gnd_pkg::REQ_DEPOSIT;
    r.word.amount               = '1;
    r.word.deposit_twenty       = c20;
    r.word.deposit_fifty        = c50;
    r.word.deposit_hundred      = c100;
    r.word.deposit_two_hundred  = c200;
    r.word.deposit_five_hundred = c500;
    r.typed                     = typed;
    r.want_ok                   = 1'b1;
    return r;
  endfunction

  // Note count for a random deposit: mostly small, rarely the full range.
  function automatic logic [gnd_pkg::DEP_W-1:0] random_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      return gnd_pkg::DEP_W'($urandom_range(0, 7));
    end else if (pick < 99) begin
      return gnd_pkg::DEP_W'($urandom_range(0, 255));
    end
    return gnd_pkg::DEP_W'($urandom_range(0, 65535));
  endfunction

  function automatic gnd_pkg::in_word_t random_word();
    gnd_pkg::in_word_t w;
    int                pick;
    longint unsigned   total;
    w.amount               = $urandom;
    w.deposit_twenty       = gnd_pkg::DEP_W'($urandom);
    w.deposit_fifty        = gnd_pkg::DEP_W'($urandom);
    w.deposit_hundred      = gnd_pkg::DEP_W'($urandom);
    w.deposit_two_hundred  = gnd_pkg::DEP_W'($urandom);
    w.deposit_five_hundred = gnd_pkg::DEP_W'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      w.req_type             = gnd_pkg::REQ_DEPOSIT;
      w.deposit_twenty       = random_count();
      w.deposit_fifty        = random_count();
      w.deposit_hundred      = random_count();
      w.deposit_two_hundred  = random_count();
      w.deposit_five_hundred = random_count();
    end else begin
      w.req_type = gnd_pkg::REQ_WITHDRAW;
      pick       = $urandom_range(0, 99);
      if (pick < 55) begin
        w.amount = 10 * $urandom_range(0, 300);
      end else if (pick < 70) begin
        w.amount = 10 * $urandom_range(0, 10000);
      end else if (pick < 82) begin
        w.amount = $urandom_range(0, 2000);
      end else if (pick >= 90) begin
        // Ask for the whole stock value, which tends to empty the stock.
        total = 0;
        for (int i = 0; i < gnd_pkg::NUM_DENOMS; i++) begin
          total = total + note_stock_model[i] * note_value[i];
        end
        if (total <= 64'hFFFF_FFFF) begin
          w.amount = gnd_pkg::AMT_W'(total);
        end
      end
    end
    return w;
  endfunction

  // Drive one word from a falling edge until it is accepted, then queue its
  // expected payout. Returns at the next falling edge with valid still high.
  task automatic send_word(input gnd_pkg::in_word_t w, input bit typed,
                           input logic want_ok);
    gnd_pkg::out_word_t want;
    if (burst_left == 0) begin
      if (!calm_mode) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    want = apply_request(w);
    if (typed) begin
      want    = '0;
      want.ok = want_ok;
    end
    pending_payouts.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_payout(input gnd_pkg::out_word_t got);
    gnd_pkg::out_word_t want;
    if (pending_payouts.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result word with none expected: ok=%0b 20=%0d 50=%0d 100=%0d 200=%0d 500=%0d",
                 got.ok, got.out_twenty, got.out_fifty, got.out_hundred,
                 got.out_two_hundred, got.out_five_hundred);
      end
    end else begin
      want = pending_payouts.pop_front();
      if (got.ok !== want.ok || got.out_twenty !== want.out_twenty ||
          got.out_fifty !== want.out_fifty || got.out_hundred !== want.out_hundred ||
          got.out_two_hundred !== want.out_two_hundred ||
          got.out_five_hundred !== want.out_five_hundred) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("payout mismatch at cycle %0d", cycle_count);
          $display("  expected ok=%0b 20=%0d 50=%0d 100=%0d 200=%0d 500=%0d",
                   want.ok, want.out_twenty, want.out_fifty, want.out_hundred,
                   want.out_two_hundred, want.out_five_hundred);
          $display("  actual   ok=%0b 20=%0d 50=%0d 100=%0d 200=%0d 500=%0d",
                   got.ok, got.out_twenty, got.out_fifty, got.out_hundred,
                   got.out_two_hundred, got.out_five_hundred);
        end
      end
    end
  endtask

  // Result side: check every word taken by the receiver.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_payout(out_data);
    end
  end

  // Receiver stall, switching between open, random and periodic stretches.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(64, 512);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN: begin
        out_stall <= 1'b0;
      end
      RX_RANDOM: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_stall <= ((rx_tick % 11) < 4);
      end
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    stim_row_t tail_rows [$];
    note_stock_model = '{default: 0};

    directed_rows = '{
      withdraw_row(32'd20, 1'b1, 1'b0),           // empty stock refuses
      withdraw_row(32'd0, 1'b1, 1'b1),            // zero amount always succeeds
      withdraw_row(32'hFFFF_FFFF, 1'b1, 1'b0),
      deposit_row(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1),
      deposit_row(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1),
      withdraw_row(32'd870),                      // one note of each kind
      withdraw_row(32'd20, 1'b1, 1'b0),           // stock is empty again
      deposit_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1),
      withdraw_row(32'd10, 1'b1, 1'b0),           // below the smallest note
      withdraw_row(32'd30, 1'b1, 1'b0),
      withdraw_row(32'd60, 1'b1, 1'b0),           // greedy 50 strands a 10
      withdraw_row(32'd80, 1'b1, 1'b0),
      withdraw_row(32'd40),
      withdraw_row(32'd0, 1'b1, 1'b1),
      withdraw_row(32'd1000),
      withdraw_row(32'd32767500),                 // every 500 note
      withdraw_row(32'd500),
      withdraw_row(32'hFFFF_FFFF),
      withdraw_row(32'hFFFF_FFF0),
      deposit_row(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1),
      deposit_row(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 1'b1),
      withdraw_row(32'd4294967000),
      withdraw_row(32'd20),
      withdraw_row(32'd123450)
    };

    // A small deposit and large withdrawals after the random run.
    tail_rows = '{
      deposit_row(16'd1, 16'd1, 16'd1, 16'd1, 16'd1),
      withdraw_row(32'd4294967000),
      withdraw_row(32'd4294967000),
      withdraw_row(32'hFFFF_FFFF)
    };

    // Synchronous reset, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want_ok);
    end

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 256 == 0) begin
        calm_mode = ($urandom_range(0, 3) == 0);
      end
      send_word(random_word(), 1'b0, 1'b0);
    end

    calm_mode = 1'b0;
    foreach (tail_rows[i]) begin
      send_word(tail_rows[i].word, tail_rows[i].typed, tail_rows[i].want_ok);
    end
    for (int k = 0; k < 12; k++) begin
      send_word(random_word(), 1'b0, 1'b0);
    end

    // Wait for the last payouts, then give the block time to misbehave.
    in_valid <= 1'b0;
    while (pending_payouts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_payouts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/gnd_pkg.sv
rtl/core/gnd_ctrl.sv
rtl/core/gnd_datapath.sv
rtl/core/greedy_note_dispenser.sv
tb/sv/greedy_note_dispenser_test.sv
